// File: design/sdacc_pkg.sv
// Shared types, constants and fp32 arithmetic functions of the sparse dot accumulator.
package sdacc_pkg;

    localparam int          FP_W      = 32;
    localparam int          IDX_W     = 2;
    localparam int          REG_IDX_W = 1;
    localparam logic [7:0]  EXP_ALL1  = 8'hFF;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;

    localparam logic [REG_IDX_W-1:0] REG_ALPHA = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_BETA  = 1'b1;

    localparam logic [IDX_W-1:0] ROW0 = 2'd0;
    localparam logic [IDX_W-1:0] ROW1 = 2'd1;
    localparam logic [IDX_W-1:0] ROW2 = 2'd2;
    localparam logic [IDX_W-1:0] ROW3 = 2'd3;

    // One queued group, B rows already selected
    typedef struct packed {
        logic [FP_W-1:0] a0;
        logic [FP_W-1:0] b0;
        logic [FP_W-1:0] a1;
        logic [FP_W-1:0] b1;
        logic [FP_W-1:0] c;
        logic            start;
        logic            last;
    } item_t;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd48;
        hit = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 6'(47 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    // Round to nearest even; m holds 24 mantissa bits then guard, round, sticky
    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                               input logic [26:0] m);
        logic [24:0]        m25;
        logic               inc;
        logic signed [11:0] er;
        inc = m[2] & ((|m[1:0]) | m[3]);
        m25 = {1'b0, m[26:3]} + 25'(inc);
        er  = e;
        if (m25[24]) begin
            m25 = m25 >> 1;
            er  = e + 12'sd1;
        end
        if (er >= 12'sd255) begin
            return {s, EXP_ALL1, 23'd0};
        end
        return {s, (m25[23] ? er[7:0] : 8'h00), m25[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic [7:0]         ea, eb;
        logic [23:0]        ma, mb;
        logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [47:0]        p;
        logic [5:0]         k;
        logic signed [11:0] er, sh, nsh;
        logic [50:0]        x, xs;
        logic [26:0]        m27;
        logic               lost;
        s      = a[31] ^ b[31];
        ea     = a[30:23];
        eb     = b[30:23];
        nan_a  = (ea == EXP_ALL1) && (a[22:0] != 23'd0);
        nan_b  = (eb == EXP_ALL1) && (b[22:0] != 23'd0);
        inf_a  = (ea == EXP_ALL1) && (a[22:0] == 23'd0);
        inf_b  = (eb == EXP_ALL1) && (b[22:0] == 23'd0);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
            return CANON_NAN;
        end
        if (inf_a || inf_b) begin
            return {s, EXP_ALL1, 23'd0};
        end
        if (zero_a || zero_b) begin
            return {s, 31'd0};
        end
        ma = {ea != 8'd0, a[22:0]};
        mb = {eb != 8'd0, b[22:0]};
        if (ea == 8'd0) ea = 8'd1;
        if (eb == 8'd0) eb = 8'd1;
        p  = ma * mb;
        k  = 6'd47 - lzc48(p);
        er = $signed({6'd0, k}) + $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd173;
        sh = $signed({6'd0, k}) - 12'sd23;
        if (er < 12'sd1) begin
            sh = sh + (12'sd1 - er);
            er = 12'sd1;
        end
        x = {p, 3'b000};
        if (sh < 12'sd0) begin
            nsh = -sh;
            m27 = x[26:0] << nsh[4:0];
        end else if (sh > 12'sd50) begin
            m27 = {26'd0, |x};
        end else begin
            xs   = x >> sh[5:0];
            lost = |(x & ~({51{1'b1}} << sh[5:0]));
            m27  = xs[26:0] | {26'd0, lost};
        end
        return round_pack(s, er, m27);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic               nan_a, nan_b, inf_a, inf_b;
        logic [31:0]        hi, lo;
        logic [7:0]         el, es, d;
        logic [26:0]        ml, xs, ms, diff, m27;
        logic [27:0]        sum;
        logic [5:0]         lz;
        logic [7:0]         shl;
        logic signed [11:0] e;
        nan_a = (a[30:23] == EXP_ALL1) && (a[22:0] != 23'd0);
        nan_b = (b[30:23] == EXP_ALL1) && (b[22:0] != 23'd0);
        inf_a = (a[30:23] == EXP_ALL1) && (a[22:0] == 23'd0);
        inf_b = (b[30:23] == EXP_ALL1) && (b[22:0] == 23'd0);
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
            return CANON_NAN;
        end
        if (inf_a) return a;
        if (inf_b) return b;
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
            return {a[31] & b[31], 31'd0};
        end
        if (a[30:0] >= b[30:0]) begin
            hi = a;
            lo = b;
        end else begin
            hi = b;
            lo = a;
        end
        el = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
        es = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
        ml = {hi[30:23] != 8'd0, hi[22:0], 3'b000};
        xs = {lo[30:23] != 8'd0, lo[22:0], 3'b000};
        d  = el - es;
        if (d >= 8'd27) begin
            ms = {26'd0, |xs};
        end else begin
            ms = (xs >> d[4:0]) | {26'd0, |(xs & ~({27{1'b1}} << d[4:0]))};
        end
        if (hi[31] == lo[31]) begin
            sum = {1'b0, ml} + {1'b0, ms};
            if (sum[27]) begin
                m27 = {sum[27:2], sum[1] | sum[0]};
                e   = $signed({4'd0, el}) + 12'sd1;
            end else begin
                m27 = sum[26:0];
                e   = $signed({4'd0, el});
            end
        end else begin
            diff = ml - ms;
            if (diff == 27'd0) begin
                return 32'd0;
            end
            lz  = lzc48({diff, 21'd0});
            shl = ({2'b00, lz} < (el - 8'd1)) ? {2'b00, lz} : (el - 8'd1);
            m27 = diff << shl[4:0];
            e   = $signed({4'd0, el}) - $signed({4'd0, shl});
        end
        return round_pack(hi[31], e, m27);
    endfunction

endpackage

// File: design/sdacc_front.sv
// Input side: accept groups, pick the two B rows and hold them in a two-entry queue.
module sdacc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [231:0]         s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 q_empty,
    output sdacc_pkg::item_t     q_head,
    input  logic                 q_pop
);
    import sdacc_pkg::*;

    localparam int DEPTH = 2;

    item_t       q_reg [DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    item_t       entry;
    logic        push;

    function automatic logic [31:0] pick_row(input logic [1:0] idx, input logic [231:0] d);
        logic [31:0] r;
        case (idx)
            ROW0:    r = d[99:68];
            ROW1:    r = d[131:100];
            ROW2:    r = d[163:132];
            ROW3:    r = d[195:164];
            default: r = d[99:68];
        endcase
        return r;
    endfunction

    always_comb
    begin
        entry.a0    = s_tdata[31:0];
        entry.a1    = s_tdata[63:32];
        entry.b0    = pick_row(s_tdata[65:64], s_tdata);
        entry.b1    = pick_row(s_tdata[67:66], s_tdata);
        entry.c     = s_tdata[227:196];
        entry.start = s_tuser;
        entry.last  = s_tlast;
    end

    assign s_tready = (count_reg != 2'(DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_empty  = (count_reg == 2'd0);
    assign q_head   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// File: design/sdacc_back.sv
// Execution side: sequence the multiplies and adds of one group on the accumulator.
module sdacc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  sdacc_pkg::item_t     q_head,
    output logic                 q_pop,
    input  logic [31:0]          alpha,
    input  logic [31:0]          beta,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata
);
    import sdacc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_P0   = 3'd1;
    localparam logic [2:0] ST_A0   = 3'd2;
    localparam logic [2:0] ST_A1   = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    item_t       item_reg, item_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] prod_reg, prod_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    item_next = q_head;
                    if (q_head.start)
                    begin
                        acc_next = fp_mul(q_head.c, beta);
                    end
                    state_next = ST_P0;
                end
            end
            ST_P0:
            begin
                prod_next  = fp_mul(item_reg.a0, item_reg.b0);
                state_next = ST_A0;
            end
            ST_A0:
            begin
                acc_next   = fp_add(acc_reg, prod_reg);
                prod_next  = fp_mul(item_reg.a1, item_reg.b1);
                state_next = ST_A1;
            end
            ST_A1:
            begin
                acc_next   = fp_add(acc_reg, prod_reg);
                state_next = item_reg.last ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = fp_mul(acc_reg, alpha);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: design/sparse_two_of_four_dot_accumulator.sv
// Top level of the 2:4 structured-sparse fp32 dot-product accumulator.
//
// Each input transfer carries one group of four B rows, the two kept A values with
// their 2-bit row indices, C, and the start (tuser) and last (tlast) marks. A start
// group loads the accumulator with C * beta; every group then adds a_first * B[index_first]
// and after it a_second * B[index_second], each product and sum rounded to nearest even
// on its own (no fused multiply-add, subnormals kept). After a last group one result
// transfer carries alpha * sum; any NaN result leaves as 0x7FC00000. The accumulator
// keeps the unscaled sum after an emit, so a group without start continues from it.
// A group runs through the execution sequencer in order (load or C * beta, first product,
// first add with second product, second add), with an emit step after it on a last group;
// the dependent chain of rounded multiplies and adds on one accumulator sets the pace.
// A two-entry queue in front lets new groups arrive while the sequencer works, and
// the result register lets the sequencer carry on while a result waits to be taken.
// Configuration: register 0 is alpha (reset 1.0), register 1 is beta (reset +0.0);
// write them only while the block is idle.
module sparse_two_of_four_dot_accumulator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_first[31:0], a_second[63:32], index_first[65:64], index_second[67:66],
    // b_row0[99:68], b_row1[131:100], b_row2[163:132], b_row3[195:164],
    // c_value[227:196], zero pad[231:228]
    input  logic [231:0] s_tdata,
    // start_flag[0]
    input  logic         s_tuser,
    // end_flag
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // d_value[31:0]
    output logic [31:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    import sdacc_pkg::*;

    logic [31:0] alpha_reg, alpha_next;
    logic [31:0] beta_reg, beta_next;
    logic        q_empty;
    logic        q_pop;
    item_t       q_head;

    // Register writes always complete in one transfer
    assign cfg_ready = 1'b1;

    always_comb
    begin
        alpha_next = alpha_reg;
        beta_next  = beta_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ALPHA: alpha_next = cfg_data;
                REG_BETA:  beta_next  = cfg_data;
                default:   alpha_next = alpha_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ONE_BITS;
            beta_reg  <= 32'd0;
        end
        else
        begin
            alpha_reg <= alpha_next;
            beta_reg  <= beta_next;
        end
    end

    // Front: accept groups, select B rows, queue them
    sdacc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    // Back: run the arithmetic and hold the result for transfer
    sdacc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .alpha    (alpha_reg),
        .beta     (beta_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
